FILE: rtl/krct_pkg.sv
// ----------------------------------------------------------------------------
// krct_pkg
// Shared sizes, key layout and operation codes for the key range count table.
// ----------------------------------------------------------------------------
package krct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int ENTRY_W     = $clog2(TABLE_DEPTH + 1);

    // key layout: 31 byte slots, first byte most significant
    localparam int KEY_SPACE = 31;
    localparam int KEY_BYTES = 31;
    localparam int KEY_W     = KEY_SPACE * 8;
    localparam int TAG_W     = 2;
    localparam int WORD_W    = KEY_W + TAG_W;

    // bytes past KEY_BYTES are forced to zero
    localparam logic [KEY_W-1:0] KEY_MASK = ~({KEY_W{1'b1}} >> (KEY_BYTES * 8));

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [ENTRY_W-1:0] FULL_CNT  = ENTRY_W'(TABLE_DEPTH);

    // operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    localparam logic [TAG_W-1:0] TAG_ANY = '0;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

FILE: rtl/key_range_count_table.sv
// ----------------------------------------------------------------------------
// key_range_count_table
// Table of unique 31-byte keys with 2-bit tags: insert, remove and
// half-open range count by tag, all done by one linear scan of the table.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Every insert, remove and query sweeps the
// whole entry memory through its single read port, one entry a cycle, and
// the block takes no new beat until the scan and its closing step are done;
// a beat with func 3 is taken in idle and does nothing. The key and tag
// store is one synchronous memory with a registered read; only the per-entry
// valid bits live in flip-flops. An insert is written back after the scan,
// so no write lands on an entry while the scan still has to compare it. A
// query result sits in an output register, and the next beat is taken
// while it waits; a second query finishing before the first is taken
// holds until the output frees up.
module key_range_count_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 func,
    input  logic [63:0]                key_w0,
    input  logic [63:0]                key_w1,
    input  logic [63:0]                key_w2,
    input  logic [55:0]                key_w3,
    input  logic [63:0]                end_w0,
    input  logic [63:0]                end_w1,
    input  logic [63:0]                end_w2,
    input  logic [55:0]                end_w3,
    input  logic [1:0]                 tag,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [krct_pkg::CNT_W-1:0] match_count
);
    import krct_pkg::*;

    // entry memory: key in the upper bits, tag in the low bits
    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]      cmp_addr_reg, cmp_addr_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [ENTRY_W-1:0]     entry_count_reg, entry_count_next;

    // operation held for the scan
    func_t              op_func_reg, op_func_next;
    logic [KEY_W-1:0]   op_key_reg, op_key_next;
    logic [KEY_W-1:0]   op_end_reg, op_end_next;
    logic [TAG_W-1:0]   op_tag_reg, op_tag_next;

    // scan results
    logic               match_found_reg, match_found_next;
    logic [ADDR_W-1:0]  match_addr_reg, match_addr_next;
    logic               free_found_reg, free_found_next;
    logic [ADDR_W-1:0]  free_addr_reg, free_addr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   match_count_reg, match_count_next;

    // compare stage signals
    logic [KEY_W-1:0]   rd_key;
    logic [TAG_W-1:0]   rd_tag;
    logic               entry_live;
    logic               key_eq;
    logic               in_range;
    logic               tag_ok;
    logic               in_accept;
    logic               out_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign match_count = match_count_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    // compare of the entry read last cycle
    assign rd_key     = rd_data_reg[WORD_W-1:TAG_W];
    assign rd_tag     = rd_data_reg[TAG_W-1:0];
    assign entry_live = cmp_vld_reg && valid_reg[cmp_addr_reg];
    assign key_eq     = (rd_key == op_key_reg);
    assign in_range   = (rd_key >= op_key_reg) && (rd_key < op_end_reg);
    assign tag_ok     = (op_tag_reg == TAG_ANY) || (rd_tag == op_tag_reg);

    // sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        scan_addr_next   = scan_addr_reg;
        cmp_vld_next     = 1'b0;
        cmp_addr_next    = scan_addr_reg;
        valid_next       = valid_reg;
        entry_count_next = entry_count_reg;
        op_func_next     = op_func_reg;
        op_key_next      = op_key_reg;
        op_end_next      = op_end_reg;
        op_tag_next      = op_tag_reg;
        match_found_next = match_found_reg;
        match_addr_next  = match_addr_reg;
        free_found_next  = free_found_reg;
        free_addr_next   = free_addr_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && out_stall;
        match_count_next = match_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = free_addr_reg;
        mem_wdata        = {op_key_reg, op_tag_reg};

        // fold in the compare result
        if (cmp_vld_reg)
        begin
            if (entry_live && key_eq && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_addr_next  = cmp_addr_reg;
            end
            if (!valid_reg[cmp_addr_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_addr_next  = cmp_addr_reg;
            end
            if (entry_live && in_range && tag_ok && (cnt_reg != CNT_MAX))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (func != FUNC_NONE))
                begin
                    op_func_next     = func_t'(func);
                    op_key_next      = {key_w0, key_w1, key_w2, key_w3} & KEY_MASK;
                    op_end_next      = {end_w0, end_w1, end_w2, end_w3} & KEY_MASK;
                    op_tag_next      = tag;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    cnt_next         = '0;
                    scan_addr_next   = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle
                cmp_vld_next = 1'b1;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                // last entry compares this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                case (op_func_reg)
                    FUNC_INSERT:
                    begin
                        if (!match_found_reg && free_found_reg && (entry_count_reg != FULL_CNT))
                        begin
                            mem_we                    = 1'b1;
                            valid_next[free_addr_reg] = 1'b1;
                            entry_count_next          = entry_count_reg + 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    FUNC_REMOVE:
                    begin
                        if (match_found_reg)
                        begin
                            valid_next[match_addr_reg] = 1'b0;
                            if (entry_count_reg != '0)
                            begin
                                entry_count_next = entry_count_reg - 1'b1;
                            end
                        end
                        state_next = ST_IDLE;
                    end
                    FUNC_QUERY:
                    begin
                        // hold until the output register is free
                        if (out_free)
                        begin
                            out_valid_next   = 1'b1;
                            match_count_next = cnt_reg;
                            state_next       = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_addr_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            valid_reg       <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_addr_reg   <= scan_addr_next;
            cmp_vld_reg     <= cmp_vld_next;
            valid_reg       <= valid_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_addr_reg    <= cmp_addr_next;
        op_func_reg     <= op_func_next;
        op_key_reg      <= op_key_next;
        op_end_reg      <= op_end_next;
        op_tag_reg      <= op_tag_next;
        match_found_reg <= match_found_next;
        match_addr_reg  <= match_addr_next;
        free_found_reg  <= free_found_next;
        free_addr_reg   <= free_addr_next;
        cnt_reg         <= cnt_next;
        match_count_reg <= match_count_next;
    end

endmodule
